[hdl/accel_ema_threshold_peak_macros.svh]
// Assertion helpers used by the RTL file of this block.
`ifndef ACCEL_EMA_THRESHOLD_PEAK_MACROS_SVH
`define ACCEL_EMA_THRESHOLD_PEAK_MACROS_SVH

// Checked only while out of reset.
`define AETP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define AETP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/aetp_pkg.sv]
`default_nettype none

package aetp_pkg;

  localparam int unsigned AVG_W       = 24;
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned THR_W       = 14;
  localparam int unsigned ALPHA_W     = 9;
  localparam int unsigned OFS_W       = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned G_FRAC_BITS = 12;
  localparam int unsigned ALPHA_FRAC  = 8;
  localparam int unsigned X_W         = 15;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [THR_W-1:0]   THR_RESET   = 14'd819;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;
  localparam logic [OFS_W-1:0]   OFS_RESET   = 14'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_ALPHA     = 2'd1,
    CFG_OFFSET    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel;
    logic                    over;
    logic                    fresh;
    logic signed [ACC_W-1:0] peak;
  } result_t;

endpackage

`default_nettype wire

[hdl/accel_ema_threshold_peak.sv]
// Smoothed single-axis accelerometer with a threshold flag and a signed peak hold. Each item
// is an ADC sample or a peak-clear command and yields exactly one result item. The block takes
// one item per clock cycle while its result is not stalled. An accepted item is registered in
// the input register; from there the moving-average update, offset removal, threshold compare
// and peak update are computed into the result register, which offers the result. That path
// holds the average feedback loop with its two parallel multipliers. A
// stalled result holds the item in the input register and stalls the input. Configuration
// writes are always ready and should only be issued while no item is in flight.
`default_nettype none
`include "accel_ema_threshold_peak_macros.svh"

module accel_ema_threshold_peak #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned AVG_FRAC_BITS = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_valid_i,
  output      logic                                    cfg_ready_o,
  input  wire logic [aetp_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [aetp_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic                                    in_valid_i,
  output      logic                                    in_stall_o,
  input  wire logic                                    action_i,
  input  wire logic [SAMPLE_BITS-1:0]                  sample_i,
  output      logic                                    out_valid_o,
  input  wire logic                                    out_stall_i,
  output      logic signed [aetp_pkg::ACC_W-1:0]       acceleration_o,
  output      logic                                    over_threshold_o,
  output      logic                                    new_peak_o,
  output      logic signed [aetp_pkg::ACC_W-1:0]       peak_value_o
);
  import aetp_pkg::*;

  localparam int unsigned XS_W     = X_W + AVG_FRAC_BITS;
  localparam int unsigned PROD_A_W = XS_W + ALPHA_W + 1;
  localparam int unsigned PROD_B_W = AVG_W + ALPHA_W + 1;
  localparam int unsigned SUM_W    = ((PROD_A_W > PROD_B_W) ? PROD_A_W : PROD_B_W) + 1;
  localparam int unsigned D_BASE_W = ((AVG_W > OFS_W + AVG_FRAC_BITS + 1) ?
                                      AVG_W : OFS_W + AVG_FRAC_BITS + 1);
  localparam int unsigned D_W      = D_BASE_W + 2;

  localparam logic signed [SUM_W-1:0] EMA_ROUND = SUM_W'(ALPHA_ONE >> 1);
  localparam logic signed [D_W-1:0]   ACC_HALF  = D_W'((64'd1 << AVG_FRAC_BITS) >> 1);

  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_action_q;
  logic [SAMPLE_BITS-1:0]   s1_sample_q;
  logic                     out_valid_q, out_valid_d;
  result_t                  res_q, res_d;
  logic signed [AVG_W-1:0]  avg_q, avg_d;
  logic signed [ACC_W-1:0]  peak_q, peak_d;
  logic [THR_W-1:0]         thr_q, thr_d;
  logic [ALPHA_W-1:0]       alpha_q, alpha_d;
  logic [OFS_W-1:0]         ofs_q, ofs_d;

  logic                     out_load;
  logic                     s1_adv;
  logic                     in_acc;
  logic                     is_sample;

  logic signed [SAMPLE_BITS-1:0] cen;
  logic signed [SAMPLE_BITS+2:0] cen_ext;
  logic signed [SAMPLE_BITS+2:0] cen6;
  logic signed [X_W-1:0]         x;
  logic signed [XS_W-1:0]        xs;
  logic [ALPHA_W-1:0]            alpha_eff;
  logic [ALPHA_W-1:0]            beta;
  logic signed [PROD_A_W-1:0]    prod_a;
  logic signed [PROD_B_W-1:0]    prod_b;
  logic signed [SUM_W-1:0]       ema_sum;
  logic signed [SUM_W-1:0]       ema;
  logic signed [AVG_W-1:0]       ema_sat;
  logic signed [D_W-1:0]         diff;
  logic signed [D_W-1:0]         diff_sh;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W:0]         acc_ext;
  logic signed [ACC_W:0]         peak_ext;
  logic [ACC_W:0]                acc_abs;
  logic [ACC_W:0]                peak_abs;
  logic                          over;
  logic                          fresh;

  // Handshake and pipeline advance.
  assign cfg_ready_o = 1'b1;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_load;
  assign in_stall_o  = s1_valid_q && !out_load;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !out_load);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_comb begin
    thr_d   = thr_q;
    alpha_d = alpha_q;
    ofs_d   = ofs_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD: thr_d   = cfg_data_i[THR_W-1:0];
        CFG_ALPHA:     alpha_d = cfg_data_i[ALPHA_W-1:0];
        CFG_OFFSET:    ofs_d   = cfg_data_i[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sample to acceleration: flipping the MSB centers the offset-binary ADC code.
  assign is_sample = (s1_action_q == ACT_SAMPLE);
  assign cen       = $signed({~s1_sample_q[SAMPLE_BITS-1], s1_sample_q[SAMPLE_BITS-2:0]});
  assign cen_ext   = (SAMPLE_BITS+3)'(cen);
  assign cen6      = (cen_ext <<< 2) + (cen_ext <<< 1);

  if (SAMPLE_BITS <= G_FRAC_BITS) begin : g_scale_up
    assign x = X_W'(cen6) <<< (G_FRAC_BITS - SAMPLE_BITS);
  end else begin : g_scale_down
    assign x = X_W'(cen6 >>> (SAMPLE_BITS - G_FRAC_BITS));
  end

  // Moving average update.
  assign xs        = XS_W'(x) <<< AVG_FRAC_BITS;
  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign beta      = ALPHA_ONE - alpha_eff;
  assign prod_a    = PROD_A_W'(xs) * PROD_A_W'($signed({1'b0, alpha_eff}));
  assign prod_b    = PROD_B_W'(avg_q) * PROD_B_W'($signed({1'b0, beta}));
  assign ema_sum   = SUM_W'(prod_a) + SUM_W'(prod_b) + EMA_ROUND;
  assign ema       = ema_sum >>> ALPHA_FRAC;

  always_comb begin
    if ((&ema[SUM_W-1:AVG_W-1]) || !(|ema[SUM_W-1:AVG_W-1])) begin
      ema_sat = AVG_W'(ema);
    end else begin
      ema_sat = {ema[SUM_W-1], {(AVG_W-1){~ema[SUM_W-1]}}};
    end
  end

  assign avg_d = is_sample ? ema_sat : avg_q;

  // Offset removal, rounding and saturation to the output width.
  assign diff    = D_W'(avg_d) - (D_W'($signed({1'b0, ofs_q})) <<< AVG_FRAC_BITS) + ACC_HALF;
  assign diff_sh = diff >>> AVG_FRAC_BITS;

  always_comb begin
    if ((&diff_sh[D_W-1:ACC_W-1]) || !(|diff_sh[D_W-1:ACC_W-1])) begin
      acc = ACC_W'(diff_sh);
    end else begin
      acc = {diff_sh[D_W-1], {(ACC_W-1){~diff_sh[D_W-1]}}};
    end
  end

  // Threshold and peak hold.
  assign acc_ext  = (ACC_W+1)'(acc);
  assign peak_ext = (ACC_W+1)'(peak_q);
  assign acc_abs  = acc_ext[ACC_W] ? unsigned'(-acc_ext) : unsigned'(acc_ext);
  assign peak_abs = peak_ext[ACC_W] ? unsigned'(-peak_ext) : unsigned'(peak_ext);
  assign over     = acc_abs > (ACC_W+1)'(thr_q);
  assign fresh    = is_sample && over && (acc_abs > peak_abs);

  always_comb begin
    if (!is_sample) begin
      peak_d = '0;
    end else if (fresh) begin
      peak_d = acc;
    end else begin
      peak_d = peak_q;
    end
  end

  always_comb begin
    res_d.accel = acc;
    res_d.over  = over;
    res_d.fresh = fresh;
    res_d.peak  = peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      peak_q      <= '0;
      thr_q       <= THR_RESET;
      alpha_q     <= ALPHA_RESET;
      ofs_q       <= OFS_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
      alpha_q     <= alpha_d;
      ofs_q       <= ofs_d;
      if (s1_adv) begin
        avg_q  <= avg_d;
        peak_q <= peak_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= action_i;
      s1_sample_q <= sample_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign acceleration_o   = res_q.accel;
  assign over_threshold_o = res_q.over;
  assign new_peak_o       = res_q.fresh;
  assign peak_value_o     = res_q.peak;

  // A new peak is only taken from an acceleration that crossed the threshold.
  `AETP_ASSERT(a_peak_needs_over, out_valid_q && res_q.fresh |-> res_q.over, "new peak without threshold crossing")
  // A new peak reports the acceleration it was taken from.
  `AETP_ASSERT(a_peak_is_accel, out_valid_q && res_q.fresh |-> (res_q.peak == res_q.accel), "new peak differs from acceleration")
  // A clear command zeroes the peak and leaves the average alone.
  `AETP_ASSERT(a_clear_peak, s1_adv && (s1_action_q == ACT_CLEAR) |=> (peak_q == '0), "clear did not zero the peak")
  `AETP_ASSERT(a_clear_avg, s1_adv && (s1_action_q == ACT_CLEAR) |=> $stable(avg_q), "clear changed the average")
  // State only moves when an item leaves the input register.
  `AETP_ASSERT(a_state_hold, !s1_adv |=> $stable(avg_q) && $stable(peak_q), "state changed without an item")

endmodule

`default_nettype wire
